[rtl/core/spct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spct_pkg: shared types and constants of the sparse pair coefficient table
// Operation and status codes, widths of the fixed item fields, and the
// control word that travels down the chain of table cells.
// ----------------------------------------------------------------------------
package spct_pkg;

  localparam int ENTRIES_DEF  = 64;
  localparam int VAR_BITS_DEF = 16;

  localparam int OP_W     = 2;
  localparam int VAR_W    = 16;
  localparam int COEF_W   = 32;
  localparam int STATUS_W = 2;
  localparam int TERM_W   = 7;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_DEL   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_NOTFOUND = 2'd1,
    STS_FULL     = 2'd2,
    STS_SAT      = 2'd3
  } status_e;

  // Control word of the token walking the chain
  typedef struct packed {
    logic    valid;
    logic    pass2;      // 0: search/modify pass, 1: insert/tally pass
    op_e     op;
    logic    found;
    logic    free_seen;
    logic    sat;
    logic    ins_pend;   // insert still waiting for a free cell
    logic    submod;
    status_e status;
  } ctl_t;

  // Result word held at the output
  typedef struct packed {
    logic signed [COEF_W-1:0] value;
    status_e                  status;
    logic                     submodular;
    logic [VAR_W-1:0]         max_var_seen;
    logic [TERM_W-1:0]        term_count;
  } res_t;

endpackage

[rtl/core/spct_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spct_in_if: request channel
// valid/ready channel carrying one table operation.
// ----------------------------------------------------------------------------
interface spct_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [spct_pkg::OP_W-1:0]            operation;
  logic [spct_pkg::VAR_W-1:0]           var_a;
  logic [spct_pkg::VAR_W-1:0]           var_b;
  logic signed [spct_pkg::COEF_W-1:0]   coeff_in;

  modport source (output valid, output operation, output var_a, output var_b,
                  output coeff_in, input ready);
  modport sink   (input valid, input operation, input var_a, input var_b,
                  input coeff_in, output ready);
endinterface

[rtl/core/spct_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spct_out_if: result channel
// valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface spct_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [spct_pkg::COEF_W-1:0]   value;
  logic [spct_pkg::STATUS_W-1:0]        status;
  logic                                 submodular;
  logic [spct_pkg::VAR_W-1:0]           max_var_seen;
  logic [spct_pkg::TERM_W-1:0]          term_count;

  modport source (output valid, output value, output status, output submodular,
                  output max_var_seen, output term_count, input ready);
  modport sink   (input valid, input value, input status, input submodular,
                  input max_var_seen, input term_count, output ready);
endinterface

[rtl/core/spct_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spct_cell: one table entry of the chain
// Holds one key pair and coefficient, acts on the token passing through and
// registers the updated token, which the next cell then receives in the next cycle.
// ----------------------------------------------------------------------------
module spct_cell #(
  parameter int VAR_BITS = spct_pkg::VAR_BITS_DEF,
  parameter int CNT_W    = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  spct_pkg::ctl_t                     ctl_i,
  input  logic [VAR_BITS-1:0]                lo_i,
  input  logic [VAR_BITS-1:0]                hi_i,
  input  logic signed [spct_pkg::COEF_W-1:0] val_i,
  input  logic [CNT_W-1:0]                   cnt_i,
  output spct_pkg::ctl_t                     ctl_o,
  output logic [VAR_BITS-1:0]                lo_o,
  output logic [VAR_BITS-1:0]                hi_o,
  output logic signed [spct_pkg::COEF_W-1:0] val_o,
  output logic [CNT_W-1:0]                   cnt_o
);

  // entry storage
  logic                               valid_q, valid_d;
  logic [VAR_BITS-1:0]                key_lo_q, key_lo_d;
  logic [VAR_BITS-1:0]                key_hi_q, key_hi_d;
  logic signed [spct_pkg::COEF_W-1:0] coef_q, coef_d;

  // token stage
  spct_pkg::ctl_t                     ctl_q, ctl_d;
  logic [VAR_BITS-1:0]                lo_q, hi_q;
  logic signed [spct_pkg::COEF_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]                   cnt_q, cnt_d;

  logic                               hit;
  logic signed [spct_pkg::COEF_W:0]   sum;
  logic                               sum_ovf;
  logic signed [spct_pkg::COEF_W-1:0] sum_sat;

  assign hit     = valid_q && (key_lo_q == lo_i) && (key_hi_q == hi_i);
  assign sum     = {coef_q[spct_pkg::COEF_W-1], coef_q} + {val_i[spct_pkg::COEF_W-1], val_i};
  assign sum_ovf = sum[spct_pkg::COEF_W] ^ sum[spct_pkg::COEF_W-1];
  assign sum_sat = !sum_ovf ? sum[spct_pkg::COEF_W-1:0] :
                   (sum[spct_pkg::COEF_W] ? spct_pkg::COEF_MIN : spct_pkg::COEF_MAX);

  always_comb begin
    ctl_d    = ctl_i;
    val_d    = val_i;
    cnt_d    = cnt_i;
    valid_d  = valid_q;
    key_lo_d = key_lo_q;
    key_hi_d = key_hi_q;
    coef_d   = coef_q;
    if (ctl_i.valid) begin
      if (!ctl_i.pass2) begin
        if (!valid_q) begin
          ctl_d.free_seen = 1'b1;
        end
        case (ctl_i.op)
          spct_pkg::OP_ACC: begin
            if (hit) begin
              coef_d      = sum_sat;
              val_d       = sum_sat;
              ctl_d.found = 1'b1;
              ctl_d.sat   = sum_ovf;
            end
          end
          spct_pkg::OP_READ: begin
            if (hit) begin
              val_d       = coef_q;
              ctl_d.found = 1'b1;
            end
          end
          spct_pkg::OP_DEL: begin
            if (hit) begin
              valid_d     = 1'b0;
              ctl_d.found = 1'b1;
            end
          end
          spct_pkg::OP_CLEAR: begin
            valid_d = 1'b0;
          end
          default: ;
        endcase
      end else begin
        if (ctl_i.ins_pend && !valid_q) begin
          valid_d        = 1'b1;
          key_lo_d       = lo_i;
          key_hi_d       = hi_i;
          coef_d         = val_i;
          ctl_d.ins_pend = 1'b0;
        end
        // tally on the entry as it stands after this operation
        if (valid_d) begin
          cnt_d = cnt_i + CNT_W'(coef_d != '0);
          if ((key_lo_d != key_hi_d) && (coef_d > 0)) begin
            ctl_d.submod = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ctl_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ctl_q   <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_lo_q <= key_lo_d;
    key_hi_q <= key_hi_d;
    coef_q   <= coef_d;
    lo_q     <= lo_i;
    hi_q     <= hi_i;
    val_q    <= val_d;
    cnt_q    <= cnt_d;
  end

  assign ctl_o = ctl_q;
  assign lo_o  = lo_q;
  assign hi_o  = hi_q;
  assign val_o = val_q;
  assign cnt_o = cnt_q;

endmodule

[rtl/core/sparse_pair_coefficient_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_pair_coefficient_table_top: bounded table of pair coefficients
// Accumulate, read, delete and clear of Q16.16 coefficients keyed by an
// unordered variable pair, held in a chain of ENTRIES table cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch_i  : request transfer (operation, var_a, var_b, coeff_in).
//   out_ch_o : result transfer (value, status, submodular, max_var_seen,
//              term_count), exactly one per request, in order.
//   A request becomes a token that walks the cell chain twice, one cell per
//   cycle. Pass one matches the key and accumulates, reads, deletes or
//   clears, and notes whether a free cell exists. Pass two places a pending
//   insert in the first free cell and tallies term count and the
//   submodular flag over all entries.
//   One request is in flight at a time: a new request is taken only once
//   the result of the last one has gone through both chain passes and
//   has been placed in the output register.
//   A stalled result waits in the output register; a second finished
//   result waits in a holding register, and the request side can take a
//   new item while the first result is still not taken.
//   Reset empties the table (all entries invalid) and clears the largest
//   index seen; key and coefficient storage is not cleared.
// ----------------------------------------------------------------------------
module sparse_pair_coefficient_table_top #(
  parameter int ENTRIES  = spct_pkg::ENTRIES_DEF,
  parameter int VAR_BITS = spct_pkg::VAR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spct_in_if.sink     in_ch_i,
  spct_out_if.source  out_ch_o
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int VW    = (VAR_BITS > spct_pkg::VAR_W) ? VAR_BITS : spct_pkg::VAR_W;
  localparam int TW    = (CNT_W > spct_pkg::TERM_W) ? CNT_W : spct_pkg::TERM_W;

  // control states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state_q, state_d;

  // chain links: stage k feeds cell k, stage ENTRIES is the tail
  spct_pkg::ctl_t                     ctl_s [ENTRIES+1];
  logic [VAR_BITS-1:0]                lo_s  [ENTRIES+1];
  logic [VAR_BITS-1:0]                hi_s  [ENTRIES+1];
  logic signed [spct_pkg::COEF_W-1:0] val_s [ENTRIES+1];
  logic [CNT_W-1:0]                   cnt_s [ENTRIES+1];
  logic [ENTRIES-1:0]                 tok_valid;

  // request side
  logic                in_fire;
  logic [VW-1:0]       a_ext, b_ext;
  logic [VAR_BITS-1:0] a_m, b_m, lo_in, hi_in;
  spct_pkg::op_e       op_in;
  logic [VAR_BITS-1:0] largest_q, largest_d;

  // result side
  spct_pkg::ctl_t tail_ctl;
  logic           done;
  logic           out_free;
  logic [VW-1:0]  largest_ext;
  logic [TW-1:0]  cnt_ext;
  spct_pkg::res_t res_tail, pend_q, out_q;
  logic           out_valid_q, out_valid_d;

  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign in_fire       = in_ch_i.valid && in_ch_i.ready;

  // mask indices to VAR_BITS, order the pair
  assign a_ext = VW'(in_ch_i.var_a);
  assign b_ext = VW'(in_ch_i.var_b);
  assign a_m   = a_ext[VAR_BITS-1:0];
  assign b_m   = b_ext[VAR_BITS-1:0];
  assign lo_in = (a_m < b_m) ? a_m : b_m;
  assign hi_in = (a_m < b_m) ? b_m : a_m;
  assign op_in = spct_pkg::op_e'(in_ch_i.operation);

  // largest index: raised by every accumulate, even a dropped one
  always_comb begin
    largest_d = largest_q;
    if (in_fire && (op_in == spct_pkg::OP_ACC) && (hi_in > largest_q)) begin
      largest_d = hi_in;
    end
  end

  assign tail_ctl = ctl_s[ENTRIES];
  assign done     = tail_ctl.valid && tail_ctl.pass2;

  // chain head: recirculate the tail after pass one, else a new request
  always_comb begin
    ctl_s[0] = '0;
    lo_s[0]  = lo_in;
    hi_s[0]  = hi_in;
    val_s[0] = in_ch_i.coeff_in;
    cnt_s[0] = '0;
    if (tail_ctl.valid && !tail_ctl.pass2) begin
      ctl_s[0]        = tail_ctl;
      ctl_s[0].pass2  = 1'b1;
      ctl_s[0].submod = 1'b1;
      lo_s[0]         = lo_s[ENTRIES];
      hi_s[0]         = hi_s[ENTRIES];
      val_s[0]        = val_s[ENTRIES];
      // settle value and status from what pass one found
      case (tail_ctl.op)
        spct_pkg::OP_ACC: begin
          if (tail_ctl.found) begin
            ctl_s[0].status = tail_ctl.sat ? spct_pkg::STS_SAT : spct_pkg::STS_OK;
          end else if (tail_ctl.free_seen) begin
            ctl_s[0].ins_pend = 1'b1;
            ctl_s[0].status   = spct_pkg::STS_OK;
          end else begin
            ctl_s[0].status = spct_pkg::STS_FULL;
            val_s[0]        = '0;
          end
        end
        spct_pkg::OP_READ: begin
          if (tail_ctl.found) begin
            ctl_s[0].status = spct_pkg::STS_OK;
          end else begin
            ctl_s[0].status = spct_pkg::STS_NOTFOUND;
            val_s[0]        = '0;
          end
        end
        spct_pkg::OP_DEL: begin
          ctl_s[0].status = tail_ctl.found ? spct_pkg::STS_OK : spct_pkg::STS_NOTFOUND;
          val_s[0]        = '0;
        end
        spct_pkg::OP_CLEAR: begin
          ctl_s[0].status = spct_pkg::STS_OK;
          val_s[0]        = '0;
        end
        default: ;
      endcase
    end else begin
      ctl_s[0].valid  = in_fire;
      ctl_s[0].op     = op_in;
      ctl_s[0].status = spct_pkg::STS_OK;
    end
  end

  // the row of table cells
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    spct_cell #(
      .VAR_BITS (VAR_BITS),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_s[k]),
      .lo_i   (lo_s[k]),
      .hi_i   (hi_s[k]),
      .val_i  (val_s[k]),
      .cnt_i  (cnt_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .lo_o   (lo_s[k+1]),
      .hi_o   (hi_s[k+1]),
      .val_o  (val_s[k+1]),
      .cnt_o  (cnt_s[k+1])
    );
    assign tok_valid[k] = ctl_s[k+1].valid;
  end

  // result assembly from the tail
  assign largest_ext = VW'(largest_q);
  assign cnt_ext     = TW'(cnt_s[ENTRIES]);

  always_comb begin
    res_tail.value        = val_s[ENTRIES];
    res_tail.status       = tail_ctl.status;
    res_tail.submodular   = tail_ctl.submod;
    res_tail.max_var_seen = largest_ext[spct_pkg::VAR_W-1:0];
    res_tail.term_count   = cnt_ext[spct_pkg::TERM_W-1:0];
  end

  assign out_free = !out_valid_q || out_ch_o.ready;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done) begin
          if (out_free) begin
            state_d     = ST_IDLE;
            out_valid_d = 1'b1;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      largest_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      largest_q   <= largest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && !out_free) begin
      pend_q <= res_tail;
    end
    if (state_q == ST_RUN && done && out_free) begin
      out_q <= res_tail;
    end else if (state_q == ST_HOLD && out_free) begin
      out_q <= pend_q;
    end
  end

  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.value        = out_q.value;
  assign out_ch_o.status       = out_q.status;
  assign out_ch_o.submodular   = out_q.submodular;
  assign out_ch_o.max_var_seen = out_q.max_var_seen;
  assign out_ch_o.term_count   = out_q.term_count;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_valid) <= 1)
    else $error("more than one token in the cell chain");

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_RUN))
    else $error("accepted request did not start a chain walk");

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (state_q == ST_RUN))
    else $error("token finished outside of a chain walk");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (cnt_s[ENTRIES] <= CNT_W'(ENTRIES)))
    else $error("term count exceeds table size");

endmodule
